@@ hdl/mma_pkg.sv @@
// shared constants and types for the matrix multiply-accumulate block
`timescale 1ns / 1ps
`default_nettype none
package mma_pkg;
    localparam int MAX_DIM   = 8;
    localparam int FRAC_BITS = 16;
    localparam int CELLS     = MAX_DIM * MAX_DIM;
    localparam int AW        = $clog2(CELLS);
    localparam int DW        = $clog2(MAX_DIM);
    localparam int ACC_W     = 64 + FRAC_BITS + DW + 2;

    localparam logic [1:0] CMD_LOAD_A  = 2'd0;
    localparam logic [1:0] CMD_LOAD_B  = 2'd1;
    localparam logic [1:0] CMD_LOAD_C  = 2'd2;
    localparam logic [1:0] CMD_COMPUTE = 2'd3;

    typedef struct packed {
        logic first;
        logic last;
        logic valid;
    } t_mac_ctl;
endpackage
`default_nettype wire

@@ hdl/mma_cell.sv @@
// one multiply-accumulate cell of the chain
`timescale 1ns / 1ps
`default_nettype none
module mma_cell (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic [mma_pkg::DW-1:0]           i_index,
    input  wire mma_pkg::t_mac_ctl                i_ctl,
    input  wire logic [mma_pkg::DW-1:0]           i_j,
    input  wire logic signed [31:0]               i_a,
    input  wire logic signed [31:0]               i_b,
    input  wire logic signed [mma_pkg::ACC_W-1:0] i_acc,
    output mma_pkg::t_mac_ctl                     o_ctl,
    output logic [mma_pkg::DW-1:0]                o_j,
    output logic signed [31:0]                    o_a,
    output logic signed [31:0]                    o_b,
    output logic signed [mma_pkg::ACC_W-1:0]      o_acc
);
    logic signed [63:0]               r_prod;
    logic signed [mma_pkg::ACC_W-1:0] r_acc;
    mma_pkg::t_mac_ctl                r_ctl0, r_ctl1;
    logic signed [mma_pkg::ACC_W-1:0] r_acc1;
    logic [mma_pkg::DW-1:0]           r_j0, r_j1;
    logic signed [31:0]               r_a0, r_a1, r_b0, r_b1;

    always_ff @(posedge i_clk) begin
        // only the cell whose index matches the term adds its product
        r_prod <= (i_j == i_index) ? i_a * i_b : 64'sd0;
        r_acc  <= i_acc;
        r_acc1 <= r_acc + mma_pkg::ACC_W'(r_prod);
        r_j0   <= i_j;
        r_j1   <= r_j0;
        r_a0   <= i_a;
        r_a1   <= r_a0;
        r_b0   <= i_b;
        r_b1   <= r_b0;
        if (!i_rst_n) begin
            r_ctl0 <= '0;
            r_ctl1 <= '0;
        end else begin
            r_ctl0 <= i_ctl;
            r_ctl1 <= r_ctl0;
        end
    end
    assign o_ctl = r_ctl1;
    assign o_acc = r_acc1;
    assign o_j   = r_j1;
    assign o_a   = r_a1;
    assign o_b   = r_b1;
endmodule
`default_nettype wire

@@ hdl/mma_sat.sv @@
// arithmetic shift and saturation back to q16.16
`timescale 1ns / 1ps
`default_nettype none
module mma_sat (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire mma_pkg::t_mac_ctl                i_ctl,
    input  wire logic signed [mma_pkg::ACC_W-1:0] i_acc,
    output mma_pkg::t_mac_ctl                     o_ctl,
    output logic signed [31:0]                    o_value
);
    logic signed [mma_pkg::ACC_W-1:0] sh;
    logic signed [31:0]               n_value;
    mma_pkg::t_mac_ctl                r_ctl;
    logic signed [31:0]               r_value;

    always_comb begin
        sh = i_acc >>> mma_pkg::FRAC_BITS;
        if (sh > mma_pkg::ACC_W'(64'sh7fffffff))        n_value = 32'sh7fffffff;
        else if (sh < -mma_pkg::ACC_W'(64'sh80000000)) n_value = 32'sh80000000;
        else                                            n_value = sh[31:0];
    end
    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        if (!i_rst_n) r_ctl <= '0;
        else          r_ctl <= i_ctl;
    end
    assign o_ctl   = r_ctl;
    assign o_value = r_value;
endmodule
`default_nettype wire

@@ hdl/matrix_multiply_accumulate.sv @@
// top level: operand stores, sequencer, mac cell chain, result write-back
// loads can follow back to back while the block is not busy
// a compute keeps busy high while it issues n*n*n terms, one term per cycle,
// then while they pass the chain of 8 cells plus read, reduce and saturation stages
// results come one element at a time after the compute is accepted, each marked
// by a strobe; the receiver cannot stall
// synchronous active-low reset clears counters and size to 8; stores are not cleared
`timescale 1ns / 1ps
`default_nettype none
module matrix_multiply_accumulate (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_command,
    input  wire logic signed [31:0] i_element_value,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [3:0]  i_cfg_matrix_size,
    output logic             o_result_strobe,
    output logic signed [31:0] o_result_value,
    output logic             o_last_element
);
    localparam int AW = mma_pkg::AW;
    localparam int DW = mma_pkg::DW;
    localparam int N  = mma_pkg::MAX_DIM;
    localparam int AC = mma_pkg::ACC_W;

    logic [31:0] r_amem [mma_pkg::CELLS];
    logic [31:0] r_bmem [mma_pkg::CELLS];
    logic [31:0] r_cmem [mma_pkg::CELLS];

    logic [3:0]    r_size;
    logic [DW:0]   n;
    logic [AW:0]   n2;
    logic [AW-1:0] r_apos, r_bpos, r_cpos;
    logic          r_run;
    logic [DW-1:0] r_i, r_k, r_j;
    logic          r_issue_done;
    logic [AW:0]   r_wb_idx;

    always_comb begin
        n = (r_size == 4'd0) ? (DW+1)'(1)
          : (r_size > 4'(N)) ? (DW+1)'(N) : r_size[DW:0];
        n2 = (AW+1)'(n) * (AW+1)'(n);
    end

    assign busy        = r_run;
    assign o_cfg_ready = !r_run && !start;

    function automatic logic [AW-1:0] nxt(input logic [AW-1:0] p, input logic [AW:0] lim);
        logic [AW:0] q;
        q = ((AW+1)'(p) >= lim) ? (AW+1)'(1) : (AW+1)'(p) + (AW+1)'(1);
        nxt = (q >= lim) ? '0 : q[AW-1:0];
    endfunction
    function automatic logic [AW-1:0] eff(input logic [AW-1:0] p, input logic [AW:0] lim);
        eff = ((AW+1)'(p) >= lim) ? '0 : p;
    endfunction

    logic accept;
    assign accept = start && !busy;

    // read addresses from sequencer
    logic [AW-1:0] a_addr, b_addr, c_addr;
    always_comb begin
        a_addr = AW'(r_i) * AW'(n) + AW'(r_j);
        b_addr = AW'(r_j) * AW'(n) + AW'(r_k);
        c_addr = AW'(r_i) * AW'(n) + AW'(r_k);
    end
    logic issue;
    assign issue = r_run && !r_issue_done;

    logic [31:0] r_ard, r_brd, r_crd;
    mma_pkg::t_mac_ctl r_rctl;
    logic [DW-1:0] r_rj;

    logic              wb_we;
    logic [AW-1:0]     wb_addr;
    logic [31:0]       wb_data;

    always_ff @(posedge i_clk) begin
        if (accept && i_command == mma_pkg::CMD_LOAD_A) r_amem[eff(r_apos, n2)] <= i_element_value;
        if (accept && i_command == mma_pkg::CMD_LOAD_B) r_bmem[eff(r_bpos, n2)] <= i_element_value;
        if (accept && i_command == mma_pkg::CMD_LOAD_C) r_cmem[eff(r_cpos, n2)] <= i_element_value;
        if (wb_we) r_cmem[wb_addr] <= wb_data;
        r_ard <= r_amem[a_addr];
        r_brd <= r_bmem[b_addr];
        r_crd <= r_cmem[c_addr];
        r_rj  <= r_j;
    end

    // sequencer over i, k, j
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= 4'd8;
            r_apos <= '0; r_bpos <= '0; r_cpos <= '0;
            r_run <= 1'b0; r_issue_done <= 1'b0;
            r_i <= '0; r_j <= '0; r_k <= '0;
            r_rctl <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) r_size <= i_cfg_matrix_size;
            r_rctl.valid <= issue;
            r_rctl.first <= issue && r_j == '0;
            r_rctl.last  <= issue && (DW+1)'(r_j) == n - (DW+1)'(1);
            if (accept) begin
                unique case (i_command)
                    mma_pkg::CMD_LOAD_A:  r_apos <= nxt(r_apos, n2);
                    mma_pkg::CMD_LOAD_B:  r_bpos <= nxt(r_bpos, n2);
                    mma_pkg::CMD_LOAD_C:  r_cpos <= nxt(r_cpos, n2);
                    mma_pkg::CMD_COMPUTE: begin
                        r_run <= 1'b1; r_issue_done <= 1'b0;
                        r_i <= '0; r_j <= '0; r_k <= '0;
                    end
                    default: ;
                endcase
            end else if (issue) begin
                if ((DW+1)'(r_j) == n - (DW+1)'(1)) begin
                    r_j <= '0;
                    if ((DW+1)'(r_k) == n - (DW+1)'(1)) begin
                        r_k <= '0;
                        if ((DW+1)'(r_i) == n - (DW+1)'(1)) r_issue_done <= 1'b1;
                        else r_i <= r_i + DW'(1);
                    end else r_k <= r_k + DW'(1);
                end else r_j <= r_j + DW'(1);
            end
            if (r_run && wb_we && (r_wb_idx + (AW+1)'(1)) == n2) begin
                r_run <= 1'b0;
                r_apos <= '0; r_bpos <= '0; r_cpos <= '0;
            end
        end
    end

    // chain of cells: each term travels with its operands, cell j adds the j-th product
    mma_pkg::t_mac_ctl         ctl [N+1];
    logic signed [AC-1:0]      acc [N+1];
    logic [DW-1:0]             op_j [N+1];
    logic signed [31:0]        op_a [N+1];
    logic signed [31:0]        op_b [N+1];

    assign ctl[0]  = r_rctl;
    assign acc[0]  = r_rctl.first ? (AC'($signed(r_crd)) <<< mma_pkg::FRAC_BITS) : '0;
    assign op_j[0] = r_rj;
    assign op_a[0] = $signed(r_ard);
    assign op_b[0] = $signed(r_brd);

    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_cell
            mma_cell u_cell (
                .i_clk  (i_clk),
                .i_rst_n(i_rst_n),
                .i_index(DW'(g)),
                .i_ctl  (ctl[g]),
                .i_j    (op_j[g]),
                .i_a    (op_a[g]),
                .i_b    (op_b[g]),
                .i_acc  (acc[g]),
                .o_ctl  (ctl[g+1]),
                .o_j    (op_j[g+1]),
                .o_a    (op_a[g+1]),
                .o_b    (op_b[g+1]),
                .o_acc  (acc[g+1])
            );
        end
    endgenerate

    // reduce: partial sums for one element leave the chain on consecutive cycles
    logic signed [AC-1:0] r_sum;
    mma_pkg::t_mac_ctl    r_sctl;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sctl <= '0;
        end else begin
            r_sctl.valid <= ctl[N].valid && ctl[N].last;
            r_sctl.last  <= 1'b0;
            r_sctl.first <= 1'b0;
        end
        if (ctl[N].valid) r_sum <= (ctl[N].first ? '0 : r_sum) + acc[N];
    end
    logic signed [AC-1:0] fin;
    assign fin = (ctl[N].first ? '0 : r_sum) + acc[N];
    logic signed [AC-1:0] r_fin;
    always_ff @(posedge i_clk) if (ctl[N].valid && ctl[N].last) r_fin <= fin;

    mma_pkg::t_mac_ctl sat_ctl;
    logic signed [31:0] sat_val;
    mma_sat u_sat (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (r_sctl),
        .i_acc  (r_fin),
        .o_ctl  (sat_ctl),
        .o_value(sat_val)
    );

    assign wb_we   = sat_ctl.valid;
    assign wb_addr = r_wb_idx[AW-1:0];
    assign wb_data = sat_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || accept) r_wb_idx <= '0;
        else if (wb_we) r_wb_idx <= r_wb_idx + (AW+1)'(1);
    end

    assign o_result_strobe = wb_we;
    assign o_result_value  = sat_val;
    assign o_last_element  = wb_we && (r_wb_idx + (AW+1)'(1)) == n2;

    a_no_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> busy) else $error("result outside compute");
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last_element |=> !busy) else $error("busy after last result");
    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready |-> !o_result_strobe) else $error("cfg ready during run");
endmodule
`default_nettype wire
